### sv/chsat_pkg.sv
// Shared types and constants of the CHS sector address tracker.
`default_nettype none

package chsat_pkg;

    localparam int unsigned CYL_W   = 16;
    localparam int unsigned HEAD_W  = 4;
    localparam int unsigned SEC_W   = 8;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned HEADS_W = 5;
    localparam int unsigned SPT_W   = 8;
    localparam int unsigned LBA_W   = 32;
    localparam int unsigned PROD1_W = CYL_W + HEADS_W + 1;
    localparam int unsigned PROD2_W = PROD1_W + SPT_W;

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;
    localparam logic [SPT_W-1:0]   SPT_RESET   = 8'd63;

    typedef enum logic {
        OP_LOAD        = 1'b0,
        OP_SECTOR_DONE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_HEADS_UNIT0 = 2'd0,
        REG_SPT_UNIT0   = 2'd1,
        REG_HEADS_UNIT1 = 2'd2,
        REG_SPT_UNIT1   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              operation;
        logic              drive_unit;
        logic [CYL_W-1:0]  start_cylinder;
        logic [HEAD_W-1:0] start_head;
        logic [SEC_W-1:0]  start_sector;
        logic [CNT_W-1:0]  start_count;
    } t_in_item;

    typedef struct packed {
        logic [LBA_W-1:0]  lba;
        logic [CYL_W-1:0]  cur_cylinder;
        logic [HEAD_W-1:0] cur_head;
        logic [SEC_W-1:0]  cur_sector;
        logic [CNT_W-1:0]  remaining;
        logic              transfer_end;
    } t_out_item;

    typedef struct packed {
        logic [HEADS_W-1:0] heads_unit0;
        logic [SPT_W-1:0]   spt_unit0;
        logic [HEADS_W-1:0] heads_unit1;
        logic [SPT_W-1:0]   spt_unit1;
    } t_geom;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic load_out;
    } t_dp_cmd;

endpackage

`default_nettype wire

### sv/chsat_regs.sv
// APB geometry registers of the two drive units.
`default_nettype none

module chsat_regs import chsat_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_geom                      o_geom
);

    t_geom    r_geom;
    t_geom    n_geom;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_geom = r_geom;

    always_comb begin
        n_geom = r_geom;
        if (w_wr) begin
            unique case (w_idx)
                REG_HEADS_UNIT0: n_geom.heads_unit0 = pwdata[HEADS_W-1:0];
                REG_SPT_UNIT0:   n_geom.spt_unit0   = pwdata[SPT_W-1:0];
                REG_HEADS_UNIT1: n_geom.heads_unit1 = pwdata[HEADS_W-1:0];
                REG_SPT_UNIT1:   n_geom.spt_unit1   = pwdata[SPT_W-1:0];
                default:         n_geom = r_geom;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_HEADS_UNIT0: prdata = {{(APB_DATA_W-HEADS_W){1'b0}}, r_geom.heads_unit0};
            REG_SPT_UNIT0:   prdata = {{(APB_DATA_W-SPT_W){1'b0}}, r_geom.spt_unit0};
            REG_HEADS_UNIT1: prdata = {{(APB_DATA_W-HEADS_W){1'b0}}, r_geom.heads_unit1};
            REG_SPT_UNIT1:   prdata = {{(APB_DATA_W-SPT_W){1'b0}}, r_geom.spt_unit1};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.heads_unit0 <= HEADS_RESET;
            r_geom.spt_unit0   <= SPT_RESET;
            r_geom.heads_unit1 <= HEADS_RESET;
            r_geom.spt_unit1   <= SPT_RESET;
        end else begin
            r_geom <= n_geom;
        end
    end

endmodule

`default_nettype wire

### sv/chsat_ctrl.sv
// Sequencing state machine and output word valid of the tracker.
`default_nettype none

module chsat_ctrl import chsat_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_free;

    assign w_free      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (w_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MUL1))
        else $error("accepted word did not start the multiply sequence");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before it was taken");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded output word not marked valid");

endmodule

`default_nettype wire

### sv/chsat_dp.sv
// Position registers, sector advance and two-step LBA datapath.
`default_nettype none

module chsat_dp import chsat_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_item i_item,
    input  wire t_geom    i_geom,
    output t_out_item     o_result
);

    logic [CYL_W-1:0]   r_cyl;
    logic [HEAD_W-1:0]  r_head;
    logic [SEC_W-1:0]   r_sec;
    logic [CNT_W-1:0]   r_left;
    logic               r_unit;
    logic [PROD1_W-1:0] r_prod1;
    logic [PROD2_W-1:0] r_prod2;
    t_out_item          r_out;

    logic [CYL_W-1:0]   n_cyl;
    logic [HEAD_W-1:0]  n_head;
    logic [SEC_W-1:0]   n_sec;
    logic [CNT_W-1:0]   n_left;
    logic               n_unit;

    logic [HEADS_W-1:0]   w_heads;
    logic [SPT_W-1:0]     w_spt;
    logic [HEADS_W-1:0]   w_head_inc;
    logic [CNT_W-1:0]     w_left_dec;
    logic [PROD1_W-2:0]   w_mul1;
    logic [PROD2_W-1:0]   w_mul2;
    logic [LBA_W-1:0]     w_lba;

    assign w_heads    = r_unit ? i_geom.heads_unit1 : i_geom.heads_unit0;
    assign w_spt      = r_unit ? i_geom.spt_unit1 : i_geom.spt_unit0;
    assign w_head_inc = {1'b0, r_head} + 5'd1;
    assign w_left_dec = r_left - 8'd1;
    assign w_mul1     = r_cyl * w_heads;
    assign w_mul2     = r_prod1 * w_spt;
    assign w_lba      = {{(LBA_W-PROD2_W){1'b0}}, r_prod2}
                        + {{(LBA_W-SEC_W){1'b0}}, r_sec} - 32'd1;
    assign o_result   = r_out;

    always_comb begin
        n_cyl  = r_cyl;
        n_head = r_head;
        n_sec  = r_sec;
        n_left = r_left;
        n_unit = r_unit;
        if (i_cmd.accept) begin
            if (t_op'(i_item.operation) == OP_LOAD) begin
                n_unit = i_item.drive_unit;
                n_cyl  = i_item.start_cylinder;
                n_head = i_item.start_head;
                n_sec  = i_item.start_sector;
                n_left = i_item.start_count;
            end else begin
                n_left = w_left_dec;
                if (w_left_dec != '0) begin
                    if (r_sec == w_spt) begin
                        n_sec = 8'd1;
                        if (w_head_inc == w_heads) begin
                            n_head = '0;
                            n_cyl  = r_cyl + 16'd1;
                        end else begin
                            n_head = w_head_inc[HEAD_W-1:0];
                        end
                    end else begin
                        n_sec = r_sec + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyl  <= '0;
            r_head <= '0;
            r_sec  <= 8'd1;
            r_left <= '0;
            r_unit <= 1'b0;
        end else begin
            r_cyl  <= n_cyl;
            r_head <= n_head;
            r_sec  <= n_sec;
            r_left <= n_left;
            r_unit <= n_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_prod1 <= {1'b0, w_mul1} + {{(PROD1_W-HEAD_W){1'b0}}, r_head};
        end
        if (i_cmd.mul2) begin
            r_prod2 <= w_mul2;
        end
        if (i_cmd.load_out) begin
            r_out.lba          <= w_lba;
            r_out.cur_cylinder <= r_cyl;
            r_out.cur_head     <= r_head;
            r_out.cur_sector   <= r_sec;
            r_out.remaining    <= r_left;
            r_out.transfer_end <= (r_left == '0);
        end
    end

endmodule

`default_nettype wire

### sv/chs_sector_address_tracker_core.sv
// Top level of the CHS sector address tracker: registers, controller and datapath.
// Usage:
//   Input channel (i_valid / o_ready, word i_item): a load word latches the start
//   cylinder, head, sector, count and drive unit; a sector-done word decrements the
//   count and, while it stays nonzero, advances the position in CHS order.
//   Output channel (o_valid / i_ready, word o_result): one word per input word with
//   the position, its LBA, the remaining count and the transfer-end flag.
//   APB port: heads and sectors per track of both units at byte addresses 0, 4, 8, 12.
// Timing:
//   A word is accepted in the idle state and then passes through MUL1, MUL2 and DONE,
//   from which the output register is loaded, raising o_valid. The LBA takes two registered
//   multiplies (cylinder by heads, then by sectors per track); the next word waits for idle.
//   The output register holds a finished word while the next one is computed; if it
//   is still full when the next result is ready, the controller holds and o_ready
//   stays low until i_ready drains it.
// Reset:
//   Synchronous, active low. Position 0/0/1, count 0, unit 0, both geometries at
//   16 heads and 63 sectors per track. No output word is pending after reset.
`default_nettype none

module chs_sector_address_tracker_core import chsat_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in_item              i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out_item                  o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_geom   w_geom;
    t_dp_cmd w_cmd;

    chsat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom)
    );

    chsat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (w_cmd)
    );

    chsat_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .i_geom   (w_geom),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### dv/chsat_checker.sv
// Checker for the CHS sector address tracker: tracks position and geometry, compares result words and register reads.
module chsat_checker import chsat_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  t_in_item                   i_in_word,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  t_out_item                  i_out_word,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    input  wire logic [APB_DATA_W-1:0] i_prdata,
    output int unsigned                o_mismatches,
    output int unsigned                o_outstanding,
    output int unsigned                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_geom             geom;
    logic [CYL_W-1:0]  trk_cyl;
    logic [HEAD_W-1:0] trk_head;
    logic [SEC_W-1:0]  trk_sec;
    logic [CNT_W-1:0]  trk_left;
    logic              trk_unit;
    t_out_item         predicted_positions[$];

    function automatic logic [HEADS_W-1:0] unit_heads();
        return trk_unit ? geom.heads_unit1 : geom.heads_unit0;
    endfunction

    function automatic logic [SPT_W-1:0] unit_spt();
        return trk_unit ? geom.spt_unit1 : geom.spt_unit0;
    endfunction

    function automatic void step_position();
        logic [HEADS_W-1:0] next_head;
        if (trk_sec == unit_spt()) begin
            trk_sec   = SEC_W'(1);
            next_head = {1'b0, trk_head} + 1'b1;
            if (next_head == unit_heads()) begin
                next_head = '0;
                trk_cyl   = trk_cyl + 1'b1;
            end
            trk_head = next_head[HEAD_W-1:0];
        end else begin
            trk_sec = trk_sec + 1'b1;
        end
    endfunction

    function automatic t_out_item track_word(t_in_item w);
        t_out_item        r;
        logic [LBA_W-1:0] acc;
        if (w.operation == OP_LOAD) begin
            trk_unit = w.drive_unit;
            trk_cyl  = w.start_cylinder;
            trk_head = w.start_head;
            trk_sec  = w.start_sector;
            trk_left = w.start_count;
        end else begin
            trk_left = trk_left - 1'b1;
            if (trk_left != '0) step_position();
        end
        acc = LBA_W'(trk_cyl) * LBA_W'(unit_heads());
        acc = acc + LBA_W'(trk_head);
        acc = acc * LBA_W'(unit_spt());
        acc = acc + LBA_W'(trk_sec) - LBA_W'(1);
        r.lba          = acc;
        r.cur_cylinder = trk_cyl;
        r.cur_head     = trk_head;
        r.cur_sector   = trk_sec;
        r.remaining    = trk_left;
        r.transfer_end = (trk_left == '0);
        return r;
    endfunction

    function automatic void check_field(string field, logic [LBA_W-1:0] want,
                                        logic [LBA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item             want;
        logic [APB_DATA_W-1:0] reg_want;
        if (!i_rst_n) begin
            geom.heads_unit0 = HEADS_RESET;
            geom.spt_unit0   = SPT_RESET;
            geom.heads_unit1 = HEADS_RESET;
            geom.spt_unit1   = SPT_RESET;
            trk_cyl          = '0;
            trk_head         = '0;
            trk_sec          = SEC_W'(1);
            trk_left         = '0;
            trk_unit         = 1'b0;
            predicted_positions.delete();
            o_mismatches     = 0;
            o_checked        = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_positions.size() == 0) begin
                    $error("result word with no expectation pending: %p", i_out_word);
                    o_mismatches++;
                end else begin
                    want = predicted_positions.pop_front();
                    check_field("lba", want.lba, i_out_word.lba);
                    check_field("cur_cylinder", LBA_W'(want.cur_cylinder),
                                LBA_W'(i_out_word.cur_cylinder));
                    check_field("cur_head", LBA_W'(want.cur_head),
                                LBA_W'(i_out_word.cur_head));
                    check_field("cur_sector", LBA_W'(want.cur_sector),
                                LBA_W'(i_out_word.cur_sector));
                    check_field("remaining", LBA_W'(want.remaining),
                                LBA_W'(i_out_word.remaining));
                    check_field("transfer_end", LBA_W'(want.transfer_end),
                                LBA_W'(i_out_word.transfer_end));
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready) predicted_positions.push_back(track_word(i_in_word));
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                        REG_HEADS_UNIT0: geom.heads_unit0 = i_pwdata[HEADS_W-1:0];
                        REG_SPT_UNIT0:   geom.spt_unit0   = i_pwdata[SPT_W-1:0];
                        REG_HEADS_UNIT1: geom.heads_unit1 = i_pwdata[HEADS_W-1:0];
                        default:         geom.spt_unit1   = i_pwdata[SPT_W-1:0];
                    endcase
                end else begin
                    case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                        REG_HEADS_UNIT0: reg_want = APB_DATA_W'(geom.heads_unit0);
                        REG_SPT_UNIT0:   reg_want = APB_DATA_W'(geom.spt_unit0);
                        REG_HEADS_UNIT1: reg_want = APB_DATA_W'(geom.heads_unit1);
                        default:         reg_want = APB_DATA_W'(geom.spt_unit1);
                    endcase
                    check_field("prdata", reg_want, i_prdata);
                end
            end
        end
        o_outstanding = predicted_positions.size();
    end

endmodule

### dv/tb_top.sv
// Testbench top for the CHS sector address tracker: stimulus, flow control and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import chsat_pkg::*;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 4;
    localparam int unsigned ITEM_TARGET    = 1550;
    localparam int unsigned RANDOM_PHASES  = 7;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_MOSTLY,
        RDY_SPARSE
    } t_ready_style;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in_item              i_item  = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_item             o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned words_sent    = 0;
    int unsigned burst_left    = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles  = 0;

    logic [HEADS_W-1:0] plan_heads [2] = '{HEADS_RESET, HEADS_RESET};
    logic [SPT_W-1:0]   plan_spt   [2] = '{SPT_RESET, SPT_RESET};

    chs_sector_address_tracker_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    chsat_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_word     (i_item),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_word    (o_result),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned  segment;
        int unsigned  span;
        t_ready_style style;
        segment = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            segment++;
            if (segment % 12 == 4) begin
                span = $urandom_range(150, 300);
                i_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else begin
                style = t_ready_style'($urandom_range(0, 3));
                span  = $urandom_range(10, 120);
                repeat (span) begin
                    case (style)
                        RDY_ALWAYS: i_ready <= 1'b1;
                        RDY_HALF:   i_ready <= 1'($urandom_range(0, 1));
                        RDY_MOSTLY: i_ready <= ($urandom_range(0, 3) != 0);
                        default:    i_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_word(input t_in_item w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_valid <= 1'b1;
        i_item  <= w;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        words_sent++;
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input t_reg_idx idx,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned h0, input int unsigned s0,
                                input int unsigned h1, input int unsigned s1);
        pause_until_drained();
        plan_heads[0] = HEADS_W'(h0);
        plan_spt[0]   = SPT_W'(s0);
        plan_heads[1] = HEADS_W'(h1);
        plan_spt[1]   = SPT_W'(s1);
        apb_access(1'b1, REG_HEADS_UNIT0,
                   ($urandom() & ~32'h1F) | APB_DATA_W'(plan_heads[0]));
        apb_access(1'b1, REG_SPT_UNIT0,
                   ($urandom() & ~32'hFF) | APB_DATA_W'(plan_spt[0]));
        apb_access(1'b1, REG_HEADS_UNIT1,
                   ($urandom() & ~32'h1F) | APB_DATA_W'(plan_heads[1]));
        apb_access(1'b1, REG_SPT_UNIT1,
                   ($urandom() & ~32'hFF) | APB_DATA_W'(plan_spt[1]));
        for (int r = 0; r < 4; r++) apb_access(1'b0, t_reg_idx'(r), '0);
        settings_used++;
    endtask

    function automatic t_in_item random_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return t_in_item'(raw[$bits(t_in_item)-1:0]);
    endfunction

    function automatic t_in_item done_word();
        t_in_item w;
        w = random_word();
        w.operation = OP_SECTOR_DONE;
        return w;
    endfunction

    function automatic t_in_item load_word(input logic unit, input logic [CYL_W-1:0] cyl,
                                           input logic [HEAD_W-1:0] head,
                                           input logic [SEC_W-1:0] sec,
                                           input logic [CNT_W-1:0] count);
        t_in_item w;
        w.operation      = OP_LOAD;
        w.drive_unit     = unit;
        w.start_cylinder = cyl;
        w.start_head     = head;
        w.start_sector   = sec;
        w.start_count    = count;
        return w;
    endfunction

    function automatic t_in_item shaped_load(input logic unit);
        t_in_item    w;
        int unsigned spt;
        int unsigned heads;
        int unsigned pick;
        spt   = plan_spt[unit];
        heads = plan_heads[unit];
        w = random_word();
        w.operation  = OP_LOAD;
        w.drive_unit = unit;
        pick = $urandom_range(0, 9);
        if (pick == 0) w.start_cylinder = '1;
        else if (pick == 1) w.start_cylinder = '0;
        if (heads >= 1 && heads <= 16 && $urandom_range(0, 1) == 1)
            w.start_head = HEAD_W'(heads - 1);
        if (spt != 0 && $urandom_range(0, 7) != 0) begin
            if ($urandom_range(0, 2) == 0)
                w.start_sector = SEC_W'($urandom_range(spt > 4 ? spt - 4 : 1, spt));
            else
                w.start_sector = SEC_W'($urandom_range(1, spt));
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) w.start_count = CNT_W'($urandom_range(0, 12));
        else if (pick < 99) w.start_count = CNT_W'($urandom_range(13, 48));
        else w.start_count = CNT_W'($urandom_range(49, 255));
        return w;
    endfunction

    task automatic run_transfers(input int unsigned stop_at);
        t_in_item    w;
        int unsigned dones;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(random_word());
            end else begin
                w = shaped_load(1'($urandom_range(0, 1)));
                send_word(w);
                dones = w.start_count;
                if ($urandom_range(0, 4) == 0) dones += $urandom_range(1, 3);
                if ($urandom_range(0, 9) == 0) dones = $urandom_range(0, dones);
                repeat (dones) send_word(done_word());
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count wraps from zero and the position advances straight out of reset
        send_word(done_word());
        send_word(load_word(1'b0, 16'h0000, 4'h0, 8'd1, 8'd0));
        send_word(load_word(1'b1, 16'hFFFF, 4'hF, 8'd63, 8'd2));
        send_word(done_word());
        send_word(done_word());
        send_word(load_word(1'b0, 16'hFFFF, 4'hF, 8'hFF, 8'hFF));
        send_word(done_word());
        send_word(done_word());
        send_word(load_word(1'b1, 16'h0000, 4'h0, 8'h00, 8'd3));
        send_word(done_word());
        send_word(t_in_item'('1));
        send_word(t_in_item'('0));

        // zero sectors per track, head counts outside the usable range
        set_geometry(0, 0, 31, 255);
        send_word(load_word(1'b0, 16'd5, 4'hF, 8'd0, 8'd5));
        send_word(done_word());
        send_word(done_word());
        send_word(load_word(1'b1, 16'd1, 4'hF, 8'd255, 8'd4));
        send_word(done_word());
        send_word(done_word());

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p) inside
                0: set_geometry(1, 1, 1, 1);
                1: set_geometry(16, 255, 16, 255);
                2: set_geometry(1, 255, 16, 1);
                [3:4]: set_geometry($urandom_range(1, 16), $urandom_range(1, 255),
                                    $urandom_range(1, 16), $urandom_range(1, 255));
                5: set_geometry($urandom_range(0, 31), $urandom_range(0, 255),
                                $urandom_range(0, 31), $urandom_range(0, 255));
                default: set_geometry(17, 2, 3, 0);
            endcase
            run_transfers(ITEM_TARGET * (p + 1) / RANDOM_PHASES);
        end
        pause_until_drained();

        $display("Sent %0d words under %0d geometry settings, %0d result words checked.",
                 words_sent, settings_used + 1, checked);
        $display("Loads, sector advances, head and cylinder carries, count wrap and odd geometry.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/chsat_pkg.sv
sv/chsat_regs.sv
sv/chsat_ctrl.sv
sv/chsat_dp.sv
sv/chs_sector_address_tracker_core.sv
dv/chsat_checker.sv
dv/tb_top.sv
